/* rtl/slab_slot_allocator_macros.svh */
// Assertion macros for the slot allocator
`ifndef SLAB_SLOT_ALLOCATOR_MACROS_SVH
`define SLAB_SLOT_ALLOCATOR_MACROS_SVH
// clocked assertion, disabled while rst_n is low
`define SSA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication: consequent checked in the cycle after the antecedent
`define SSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/ssa_pkg.sv */
// Package: widths, constants and codes of the slot allocator
package ssa_pkg;
    localparam int MAX_SLABS  = 16;
    localparam int MAX_SLOTS  = 64;
    localparam int BATCH      = 32;
    localparam int LINK_DEPTH = 1024;
    localparam int HW         = 10;
    localparam int LW         = 11;
    localparam int BW         = 27;
    localparam logic [LW-1:0] NIL = 11'd1024;
    localparam logic [BW-1:0] BYTES_MAX = 27'h7FFFFFF;
    localparam logic [1:0] REG_OBJ  = 2'd0;
    localparam logic [1:0] REG_SLOTS = 2'd1;
    localparam logic [1:0] REG_SLAB = 2'd2;
    localparam logic [0:0] FUNC_ALLOC = 1'b0;
    localparam logic [0:0] FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic           we;
        logic [HW-1:0]  waddr;
        logic [LW-1:0]  wdata;
        logic           re;
        logic [HW-1:0]  raddr;
    } t_mem_req;

    typedef struct packed {
        logic [26:0] used;
        logic [26:0] peak;
        logic [26:0] cap;
        logic [31:0] allocs;
        logic [31:0] fails;
        logic [31:0] frees;
    } t_stats;

    function automatic logic [BW-1:0] sat_add(input logic [BW-1:0] a,
                                              input logic [BW-1:0] b);
        logic [BW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[BW] ? BYTES_MAX : s[BW-1:0];
    endfunction
endpackage

/* rtl/ssa_req_if.sv */
// Request and response channel interfaces
interface ssa_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [16:0] request_size;
    logic [9:0]  slot_handle;
    logic        handle_valid;
    modport source (output valid, func, request_size, slot_handle, handle_valid,
                    input ready);
    modport sink (input valid, func, request_size, slot_handle, handle_valid,
                  output ready);
endinterface

interface ssa_rsp_if;
    logic        valid;
    logic        ready;
    logic        granted;
    logic [9:0]  given_handle;
    logic [26:0] used_bytes;
    logic [26:0] peak_bytes;
    logic [26:0] capacity_bytes;
    logic [31:0] alloc_count;
    logic [31:0] fail_count;
    logic [31:0] free_count;
    modport source (output valid, granted, given_handle, used_bytes, peak_bytes,
                    capacity_bytes, alloc_count, fail_count, free_count,
                    input ready);
    modport sink (input valid, granted, given_handle, used_bytes, peak_bytes,
                  capacity_bytes, alloc_count, fail_count, free_count,
                  output ready);
endinterface

/* rtl/ssa_link_ram.sv */
// Next-pointer memory, one write and one registered read port
module ssa_link_ram (
    input  logic                     i_clk,
    input  ssa_pkg::t_mem_req        i_req,
    output logic [ssa_pkg::LW-1:0]   o_rdata
);
    logic [ssa_pkg::LW-1:0] mem [ssa_pkg::LINK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= mem[i_req.raddr];
        end
    end
endmodule

/* rtl/slab_slot_allocator.sv */
// Top level: slot allocator sequencer over the link memory
//  channel   dir  beat
//  i_req     in   func, request_size, slot_handle, handle_valid
//  o_rsp     out  granted, given_handle, usage counters
//  cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data
// One item at a time. Free, null free or refused allocate: result via S_OUT; magazine pop:
// S_POP reads the link memory, S_POPW takes the slot, then S_OUT. Growth links the new slab's
// slots in S_LINK, a refill walk takes up to BATCH slots; both run ahead of the pop.
// Results sit in an output register; stalls hold it, and the next request is taken
// the cycle after the result beat. Synchronous reset, no clear pass.
`include "slab_slot_allocator_macros.svh"
module slab_slot_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssa_req_if.sink     i_req,
    ssa_rsp_if.source   o_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [22:0] i_cfg_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP  = 3'd1;
    localparam logic [2:0] S_POPW = 3'd2;
    localparam logic [2:0] S_LINK = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_WALKW = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  r_st, n_st;
    logic [16:0] r_obj;
    logic [6:0]  r_slots;
    logic [22:0] r_slab;
    logic [ssa_pkg::LW-1:0] r_mag, n_mag, r_cen, n_cen, r_tail, n_tail;
    logic [4:0]  r_slabs, n_slabs;
    logic [6:0]  r_n, n_n;
    logic [8:0]  r_cnt, n_cnt;
    logic [ssa_pkg::LW-1:0] r_base, n_base;
    ssa_pkg::t_stats r_s, n_s;
    logic        r_vld, n_vld, r_gr, n_gr;
    logic [9:0]  r_gh, n_gh;
    ssa_pkg::t_mem_req w_mem;
    logic [ssa_pkg::LW-1:0] w_rd, w_h;
    logic [6:0]  w_lim;

    ssa_link_ram u_ram (.i_clk(i_clk), .i_req(w_mem), .o_rdata(w_rd));

    assign i_req.ready = (r_st == S_IDLE) && !r_vld;
    assign o_rsp.valid = r_vld;
    assign o_rsp.granted = r_gr;
    assign o_rsp.given_handle = r_gh;
    assign o_rsp.used_bytes = r_s.used;
    assign o_rsp.peak_bytes = r_s.peak;
    assign o_rsp.capacity_bytes = r_s.cap;
    assign o_rsp.alloc_count = r_s.allocs;
    assign o_rsp.fail_count = r_s.fails;
    assign o_rsp.free_count = r_s.frees;
    assign w_lim = (r_slots > 7'(ssa_pkg::MAX_SLOTS)) ? 7'(ssa_pkg::MAX_SLOTS) : r_slots;
    assign w_h = r_base + ssa_pkg::LW'(r_n) - 11'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj <= 17'd16; r_slots <= 7'd64; r_slab <= 23'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ssa_pkg::REG_OBJ:   r_obj <= i_cfg_data[16:0];
                ssa_pkg::REG_SLOTS: r_slots <= i_cfg_data[6:0];
                ssa_pkg::REG_SLAB:  r_slab <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_st = r_st; n_mag = r_mag; n_cen = r_cen; n_tail = r_tail;
        n_slabs = r_slabs; n_n = r_n; n_cnt = r_cnt; n_base = r_base;
        n_s = r_s; n_vld = r_vld; n_gr = r_gr; n_gh = r_gh;
        w_mem = '0;
        if (r_vld && o_rsp.ready) n_vld = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_gr = 1'b0; n_gh = '0;
                    if (i_req.func == ssa_pkg::FUNC_ALLOC) begin
                        n_s.allocs = r_s.allocs + 32'd1;
                        if (i_req.request_size > r_obj) begin
                            n_s.fails = r_s.fails + 32'd1;
                            n_st = S_OUT;
                        end else if (r_mag != ssa_pkg::NIL) begin
                            n_st = S_POP;
                        end else if (r_cen != ssa_pkg::NIL) begin
                            n_st = S_WALK;
                        end else if (r_slabs < 5'(ssa_pkg::MAX_SLABS)) begin
                            n_slabs = r_slabs + 5'd1;
                            n_s.cap = ssa_pkg::sat_add(r_s.cap, 27'(r_slab));
                            n_base = ssa_pkg::LW'(r_slabs) * ssa_pkg::LW'(ssa_pkg::MAX_SLOTS);
                            n_n = w_lim;
                            n_st = S_LINK;
                        end else begin
                            n_s.fails = r_s.fails + 32'd1;
                            n_st = S_OUT;
                        end
                    end else if (i_req.handle_valid) begin
                        n_gr = 1'b1;
                        n_s.frees = r_s.frees + 32'd1;
                        n_s.used = (r_s.used > 27'(r_obj)) ? r_s.used - 27'(r_obj) : '0;
                        w_mem.we = 1'b1;
                        w_mem.waddr = i_req.slot_handle;
                        w_mem.wdata = r_mag;
                        n_mag = {1'b0, i_req.slot_handle};
                        n_st = S_OUT;
                    end else begin
                        n_st = S_OUT;
                    end
                end
            end
            S_LINK: begin
                if (r_n == 7'd0) begin
                    if (r_cen == ssa_pkg::NIL) begin
                        n_s.fails = r_s.fails + 32'd1;
                        n_st = S_OUT;
                    end else begin
                        n_st = S_WALK;
                    end
                end else begin
                    n_n = r_n - 7'd1;
                    if (!w_h[10]) begin
                        w_mem.we = 1'b1;
                        w_mem.waddr = w_h[9:0];
                        w_mem.wdata = r_cen;
                        n_cen = w_h;
                    end
                end
            end
            S_WALK: begin
                n_tail = r_cen; n_cnt = 9'd1;
                w_mem.re = 1'b1; w_mem.raddr = r_cen[9:0];
                n_st = S_WALKW;
            end
            S_WALKW: begin
                if (w_rd != ssa_pkg::NIL && r_cnt < 9'(ssa_pkg::BATCH)) begin
                    n_tail = w_rd; n_cnt = r_cnt + 9'd1;
                    w_mem.re = 1'b1; w_mem.raddr = w_rd[9:0];
                end else begin
                    n_mag = r_cen; n_cen = w_rd;
                    w_mem.we = 1'b1; w_mem.waddr = r_tail[9:0];
                    w_mem.wdata = ssa_pkg::NIL;
                    n_st = S_POP;
                end
            end
            S_POP: begin
                w_mem.re = 1'b1; w_mem.raddr = r_mag[9:0];
                n_st = S_POPW;
            end
            S_POPW: begin
                n_gr = 1'b1; n_gh = r_mag[9:0]; n_mag = w_rd;
                n_s.used = ssa_pkg::sat_add(r_s.used, 27'(r_obj));
                if (n_s.used > r_s.peak) n_s.peak = n_s.used;
                n_st = S_OUT;
            end
            S_OUT: begin
                n_vld = 1'b1; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_mag <= ssa_pkg::NIL; r_cen <= ssa_pkg::NIL;
            r_slabs <= '0; r_s <= '0; r_vld <= 1'b0;
        end else begin
            r_st <= n_st; r_mag <= n_mag; r_cen <= n_cen;
            r_slabs <= n_slabs; r_s <= n_s; r_vld <= n_vld;
        end
        r_tail <= n_tail; r_n <= n_n; r_cnt <= n_cnt; r_base <= n_base;
        r_gr <= n_gr; r_gh <= n_gh;
    end

    `SSA_ASSERT(a_busy_no_ready, i_clk, i_rst_n, !(r_st != S_IDLE && i_req.ready), "ready while busy")
    `SSA_ASSERT(a_peak_ge_used, i_clk, i_rst_n, r_s.peak >= r_s.used, "peak below used")
    `SSA_ASSERT_NEXT(a_out_valid, i_clk, i_rst_n, r_st == S_OUT, r_vld, "result not shown")
    `SSA_ASSERT(a_slabs_cap, i_clk, i_rst_n, r_slabs <= 5'(ssa_pkg::MAX_SLABS), "slab count over limit")
endmodule
